// ===== hw/rtl/ttmdc_pkg.sv =====
// Shared types and constants for the torque to motor drive command block.
// No dependencies.
package ttmdc_pkg;

  localparam int TorqW = 24;
  localparam int AngW  = 19;
  localparam int RateW = 25;
  localparam int BusW  = 22;
  localparam int CurW  = 23;
  localparam int VoltW = 27;
  localparam int DutyW = 17;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 23;

  localparam logic signed [VoltW-1:0] VMax = 27'sd67108863;
  localparam logic signed [VoltW-1:0] VMin = -27'sd67108864;
  localparam logic [DutyW-1:0] DutyFull = 17'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CPT  = 3'd0,
    REG_EMF  = 3'd1,
    REG_RES  = 3'd2,
    REG_IMAX = 3'd3,
    REG_TMAX = 3'd4,
    REG_LO   = 3'd5,
    REG_HI   = 3'd6,
    REG_POL  = 3'd7
  } reg_idx_t;

  localparam logic [1:0] PolPos = 2'd1;
  localparam logic [1:0] PolNeg = 2'd2;

  typedef struct packed {
    logic [19:0] cpt;
    logic [21:0] emf;
    logic [21:0] res;
    logic [21:0] imax;
    logic [22:0] tmax;
    logic signed [AngW-1:0] lo;
    logic signed [AngW-1:0] hi;
    logic [1:0] pol;
  } cfg_t;

  // classified item between front and back
  typedef struct packed {
    logic invalid;
    logic brk;
    logic sat;
    logic signed [TorqW-1:0] torque;
    logic signed [RateW-1:0] rate;
    logic [BusW-1:0] bus;
  } cmd_t;

  typedef struct packed {
    logic signed [TorqW-1:0] torque;
    logic signed [CurW-1:0] cur;
    logic signed [VoltW-1:0] volt;
    logic [DutyW-1:0] duty;
    logic in1;
    logic sat;
    logic brk;
    logic vld;
  } res_t;

  localparam int CmdW = $bits(cmd_t);
  localparam int ResW = $bits(res_t);

endpackage

// ===== hw/rtl/ttmdc_front.sv =====
// Front: clamps torque, checks settings, classifies brake cases.
// Depends on ttmdc_pkg.
module ttmdc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [23:0]          torque_request,
  input  logic signed [18:0]          fin_angle,
  input  logic signed [24:0]          fin_rate,
  input  logic [21:0]                 bus_voltage,
  input  ttmdc_pkg::cfg_t             cfg,
  output logic                        q_valid,
  input  logic                        q_ready,
  output ttmdc_pkg::cmd_t             q_cmd
);
  import ttmdc_pkg::*;

  logic signed [TorqW:0] tq_ext, tmax_s;
  logic signed [TorqW-1:0] tq;
  logic tq_sat, bad;
  cmd_t cmd;

  assign tq_ext = {torque_request[TorqW-1], torque_request};
  assign tmax_s = {2'b00, cfg.tmax};

  always_comb begin
    tq = torque_request;
    tq_sat = 1'b0;
    if (tq_ext > tmax_s) begin
      tq = {1'b0, cfg.tmax};
      tq_sat = 1'b1;
    end else if (tq_ext < -tmax_s) begin
      tq = TorqW'(-tmax_s);
      tq_sat = 1'b1;
    end
    bad = (cfg.cpt == '0) || (cfg.emf == '0) || (cfg.res == '0) || (cfg.imax == '0) ||
          (cfg.tmax == '0) || (cfg.pol != PolPos && cfg.pol != PolNeg) ||
          (cfg.lo >= cfg.hi) || (bus_voltage == '0);
    cmd.invalid = bad;
    cmd.brk = !bad && ((fin_angle >= cfg.hi && !tq[TorqW-1]) ||
                       (fin_angle <= cfg.lo && (tq[TorqW-1] || tq == '0)));
    cmd.sat = tq_sat;
    cmd.torque = tq;
    cmd.rate = fin_rate;
    cmd.bus = bus_voltage;
  end

  // one-deep registered stage; accepts when empty or draining
  assign in_ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_cmd <= cmd;
    end
  end
endmodule

// ===== hw/rtl/ttmdc_queue.sv =====
// Short FIFO between front and back (two entries, flop based).
// Depends on ttmdc_pkg.
module ttmdc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  ttmdc_pkg::cmd_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output ttmdc_pkg::cmd_t rd_data
);
  import ttmdc_pkg::*;

  cmd_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic wr, rd;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) (cnt == 2'd0) |-> !rd)
    else $error("read from empty queue");
  assert property (@(posedge clk) disable iff (rst) (wr && !rd) |=> cnt == $past(cnt) + 2'd1)
    else $error("queue count mismatch");
endmodule

// ===== hw/rtl/ttmdc_back.sv =====
// Back: pipelined current, voltage and duty computation.
// Stages: current mult, current round/clamp, voltage mults, voltage sum/sat,
// divider entry register, 17-stage restoring divider; result assembled from
// the last stage. Depends on ttmdc_pkg.
module ttmdc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ttmdc_pkg::cmd_t in_cmd,
  input  ttmdc_pkg::cfg_t cfg,
  output logic            out_valid,
  input  logic            out_ready,
  output ttmdc_pkg::res_t out_res
);
  import ttmdc_pkg::*;

  localparam int DivSteps = 17;
  localparam int NumW = 43;  // |V| (26 bits) << 16 plus guard
  localparam int Depth = 5 + DivSteps;

  // pipeline advances as a whole when the last stage can move
  logic adv;
  logic [Depth-1:0] v;

  assign adv = !v[Depth-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = v[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (adv) v <= {v[Depth-2:0], in_valid};
  end

  // stage 1: torque * gain
  cmd_t c1;
  logic signed [44:0] p1;
  always_ff @(posedge clk) if (adv) begin
    c1 <= in_cmd;
    p1 <= 45'(in_cmd.torque) * $signed({1'b0, cfg.cpt});
  end

  // stage 2: round and clamp current
  cmd_t c2;
  logic signed [CurW-1:0] cur2, cur2_next;
  logic sat2, sat2_next;
  logic [44:0] m1;
  logic signed [30:0] r1;
  logic signed [30:0] imx;
  always_comb begin
    m1 = p1[44] ? 45'(-p1) : 45'(p1);
    r1 = p1[44] ? -31'((m1 + 45'd32768) >> 16) : 31'((m1 + 45'd32768) >> 16);
    imx = 31'(cfg.imax);
    cur2_next = CurW'(r1);
    sat2_next = c1.sat;
    if (r1 > imx) begin
      cur2_next = CurW'(imx); sat2_next = 1'b1;
    end else if (r1 < -imx) begin
      cur2_next = CurW'(-imx); sat2_next = 1'b1;
    end
  end
  always_ff @(posedge clk) if (adv) begin
    c2 <= c1;
    cur2 <= cur2_next;
    sat2 <= sat2_next;
  end

  // stage 3: two products
  cmd_t c3;
  logic signed [CurW-1:0] cur3;
  logic sat3;
  logic signed [45:0] pa;
  logic signed [47:0] pb;
  always_ff @(posedge clk) if (adv) begin
    c3 <= c2; cur3 <= cur2; sat3 <= sat2;
    pa <= 46'(cur2) * $signed({1'b0, cfg.res});
    pb <= 48'(c2.rate) * $signed({1'b0, cfg.emf});
  end

  // stage 4: sum, round, saturate
  cmd_t c4;
  logic signed [CurW-1:0] cur4;
  logic sat4, sat4_next;
  logic signed [VoltW-1:0] volt4, volt4_next;
  logic [25+1:0] mag4, mag4_next;
  logic signed [47:0] sum;
  logic [47:0] ms;
  logic signed [32:0] rv;
  always_comb begin
    sum = 48'(pa) + pb;
    ms = sum[47] ? 48'(-sum) : 48'(sum);
    rv = sum[47] ? -33'((ms + 48'd32768) >> 16) : 33'((ms + 48'd32768) >> 16);
    sat4_next = sat3;
    if (rv > 33'(VMax)) begin
      volt4_next = VMax; mag4_next = 27'(VMax); sat4_next = 1'b1;
    end else if (rv < 33'(VMin)) begin
      volt4_next = VMin; mag4_next = 27'd67108864; sat4_next = 1'b1;
    end else begin
      volt4_next = VoltW'(rv);
      mag4_next = rv[32] ? 27'(-rv) : 27'(rv);
    end
  end
  always_ff @(posedge clk) if (adv) begin
    c4 <= c3; cur4 <= cur3;
    sat4 <= sat4_next;
    volt4 <= volt4_next;
    mag4 <= mag4_next;
  end

  // divider: one quotient bit per stage, |V|<<16 / bus
  typedef struct packed {
    cmd_t c;
    logic signed [CurW-1:0] cur;
    logic signed [VoltW-1:0] volt;
    logic sat;
    logic full;
    logic [NumW-1:0] rem;
    logic [DivSteps-1:0] q;
  } dv_t;

  dv_t dv [DivSteps+1];
  dv_t d_in;
  always_comb begin
    d_in.c = c4;
    d_in.cur = cur4;
    d_in.volt = volt4;
    d_in.full = 27'(mag4) >= 27'(c4.bus);
    d_in.sat = sat4 || (27'(mag4) > 27'(c4.bus));
    // remainder starts as |V| (quotient < 2^17 since |V| < bus when used)
    d_in.rem = NumW'(mag4);
    d_in.q = '0;
  end

  always_ff @(posedge clk) if (adv) dv[0] <= d_in;

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic [NumW-1:0] sh;
    logic [NumW-1:0] dvs;
    dv_t dv_next;
    always_comb begin
      sh = (k == 0) ? dv[k].rem : {dv[k].rem[NumW-2:0], 1'b0};
      dvs = NumW'(dv[k].c.bus);
      dv_next = dv[k];
      if (sh >= dvs) begin
        dv_next.rem = sh - dvs;
        dv_next.q = {dv[k].q[DivSteps-2:0], 1'b1};
      end else begin
        dv_next.rem = sh;
        dv_next.q = {dv[k].q[DivSteps-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) if (adv) dv[k+1] <= dv_next;
  end

  // final result assembly (combinational from last stage register)
  dv_t f;
  logic pos;
  assign f = dv[DivSteps];
  assign pos = !f.volt[VoltW-1];
  always_comb begin
    out_res = '0;
    if (f.c.invalid) begin
      out_res = '0;
    end else if (f.c.brk) begin
      out_res.in1 = 1'b1; out_res.sat = 1'b1; out_res.brk = 1'b1; out_res.vld = 1'b1;
    end else begin
      out_res.torque = f.c.torque;
      out_res.cur = f.cur;
      out_res.volt = f.volt;
      // first step tested |V| >= bus without shift; it sets bit 16 only when full
      out_res.duty = f.full ? DutyFull : f.q;
      out_res.in1 = (cfg.pol == PolPos) ? pos : !pos;
      out_res.sat = f.sat;
      out_res.vld = 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_res))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.brk) |-> out_res.vld && out_res.duty == '0)
    else $error("brake result malformed");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.duty <= DutyFull)
    else $error("duty out of range");
endmodule

// ===== hw/rtl/torque_to_motor_drive_command.sv =====
// Top level: config registers, front classifier, queue, arithmetic back end.
// Depends on ttmdc_pkg, ttmdc_front, ttmdc_queue, ttmdc_back.
//
// Usage:
//  s_axis carries one control sample per transfer; m_axis returns one
//  command per sample, in order. cfg_valid/cfg_ready write register
//  cfg_index with cfg_data (index 0..7 in register list order; indexes
//  beyond are ignored). Write config only while the block is idle.
//  The path runs through the front register, the queue, the current and
//  voltage multiplier stages, and a 17-stage restoring divider for duty.
//  Throughput: one sample per cycle while the receiver does not stall.
//  When the receiver stalls, the back pipeline freezes, the queue fills,
//  then s_axis_tready drops; nothing is lost. Reset clears all valid
//  state and loads register defaults; motor_polarity resets to 0, so
//  results are invalid (all zero) until it is written.
module torque_to_motor_drive_command (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [23:0] torque_request, [42:24] fin_angle, [67:43] fin_rate,
  // [89:68] bus_voltage, [95:90] zero
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [23:0] torque_applied, [46:24] motor_current, [73:47] drive_voltage,
  // [90:74] duty, [91] in1_positive, [92] saturated, [93] brake,
  // [94] valid_res, [95] zero
  output logic [95:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [22:0] cfg_data
);
  import ttmdc_pkg::*;

  cfg_t cfg;
  cmd_t fq_cmd, qb_cmd;
  res_t res;
  logic fq_valid, fq_ready, qb_valid, qb_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cpt  <= 20'd65536;
      cfg.emf  <= 22'd65536;
      cfg.res  <= 22'd65536;
      cfg.imax <= 22'd65536;
      cfg.tmax <= 23'd65536;
      cfg.lo   <= -19'sd65536;
      cfg.hi   <= 19'sd65536;
      cfg.pol  <= 2'd0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_CPT:  cfg.cpt  <= cfg_data[19:0];
        REG_EMF:  cfg.emf  <= cfg_data[21:0];
        REG_RES:  cfg.res  <= cfg_data[21:0];
        REG_IMAX: cfg.imax <= cfg_data[21:0];
        REG_TMAX: cfg.tmax <= cfg_data[22:0];
        REG_LO:   cfg.lo   <= cfg_data[18:0];
        REG_HI:   cfg.hi   <= cfg_data[18:0];
        REG_POL:  cfg.pol  <= cfg_data[1:0];
        default:  cfg.pol  <= cfg.pol;
      endcase
    end
  end

  ttmdc_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .torque_request(s_axis_tdata[23:0]), .fin_angle(s_axis_tdata[42:24]),
    .fin_rate(s_axis_tdata[67:43]), .bus_voltage(s_axis_tdata[89:68]),
    .cfg, .q_valid(fq_valid), .q_ready(fq_ready), .q_cmd(fq_cmd)
  );

  ttmdc_queue u_queue (
    .clk, .rst,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_cmd),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_cmd)
  );

  ttmdc_back u_back (
    .clk, .rst,
    .in_valid(qb_valid), .in_ready(qb_ready), .in_cmd(qb_cmd), .cfg,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
  );

  assign m_axis_tdata = {1'b0, res.vld, res.brk, res.sat, res.in1, res.duty,
                         res.volt, res.cur, res.torque};
endmodule

// ===== sim/torque_to_motor_drive_command_tb.sv =====
// Self-checking bench for torque_to_motor_drive_command: directed and random
// control samples under random stalls, predicted in-bench. Depends on ttmdc_pkg.
`timescale 1ns / 1ps

module torque_to_motor_drive_command_tb;
  import ttmdc_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [95:0] m_axis_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [22:0] cfg_data = '0;

  torque_to_motor_drive_command dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // bench copy of the registers
  logic [19:0] g_cpt;
  logic [21:0] g_emf, g_res, g_imax;
  logic [22:0] g_tmax;
  logic signed [18:0] g_lo, g_hi;
  logic [1:0] g_pol;

  res_t cmd_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int rx_stall = 0;
  bit quiet = 0;

  function automatic res_t drive_cmd(logic signed [23:0] treq, logic signed [18:0] ang,
                                     logic signed [24:0] rate, logic [21:0] bus);
    res_t r;
    longint t, c, v, mag;
    bit sat;
    r = '0;
    if (g_cpt == 0 || g_emf == 0 || g_res == 0 || g_imax == 0 || g_tmax == 0 ||
        g_pol == 0 || g_pol == 3 || g_lo >= g_hi || bus == 0) return r;
    sat = 0;
    t = longint'(treq);
    if (t > longint'(g_tmax)) begin t = longint'(g_tmax); sat = 1; end
    else if (t < -longint'(g_tmax)) begin t = -longint'(g_tmax); sat = 1; end
    if ((ang >= g_hi && t >= 0) || (ang <= g_lo && t <= 0)) begin
      r.in1 = 1; r.sat = 1; r.brk = 1; r.vld = 1;
      return r;
    end
    c = t * longint'(g_cpt);
    c = (c < 0) ? -((-c + 32768) >>> 16) : ((c + 32768) >>> 16);
    if (c > longint'(g_imax)) begin c = longint'(g_imax); sat = 1; end
    else if (c < -longint'(g_imax)) begin c = -longint'(g_imax); sat = 1; end
    v = c * longint'(g_res) + longint'(rate) * longint'(g_emf);
    v = (v < 0) ? -((-v + 32768) >>> 16) : ((v + 32768) >>> 16);
    if (v > 67108863) begin v = 67108863; sat = 1; end
    else if (v < -67108864) begin v = -67108864; sat = 1; end
    mag = (v < 0) ? -v : v;
    if (mag >= longint'(bus)) begin
      r.duty = DutyFull;
      if (mag > longint'(bus)) sat = 1;
    end else r.duty = 17'((mag << 16) / longint'(bus));
    r.torque = 24'(t);
    r.cur = 23'(c);
    r.volt = 27'(v);
    r.in1 = (g_pol == PolPos) ? (v >= 0) : (v < 0);
    r.sat = sat;
    r.vld = 1;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // receiver: random stall bursts, compare each transfer
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 0;
    else begin
      if (m_axis_tvalid && m_axis_tready) begin
        res_t g, w;
        g = '0;
        g.torque = m_axis_tdata[23:0];
        g.cur = m_axis_tdata[46:24];
        g.volt = m_axis_tdata[73:47];
        g.duty = m_axis_tdata[90:74];
        g.in1 = m_axis_tdata[91];
        g.sat = m_axis_tdata[92];
        g.brk = m_axis_tdata[93];
        g.vld = m_axis_tdata[94];
        if (cmd_q.size() == 0) report("unexpected", m_axis_tdata[63:0], 0);
        else begin
          w = cmd_q.pop_front();
          if (g.torque !== w.torque) report("torque_applied", g.torque, w.torque);
          if (g.cur !== w.cur) report("motor_current", g.cur, w.cur);
          if (g.volt !== w.volt) report("drive_voltage", g.volt, w.volt);
          if (g.duty !== w.duty) report("duty", g.duty, w.duty);
          if (g.in1 !== w.in1) report("in1_positive", g.in1, w.in1);
          if (g.sat !== w.sat) report("saturated", g.sat, w.sat);
          if (g.brk !== w.brk) report("brake", g.brk, w.brk);
          if (g.vld !== w.vld) report("valid_res", g.vld, w.vld);
        end
      end
      if (quiet) m_axis_tready <= 1;
      else if (rx_stall > 0) begin
        m_axis_tready <= 0;
        rx_stall <= rx_stall - 1;
      end else if ($urandom_range(0, 15) == 0) begin
        m_axis_tready <= 0;
        rx_stall <= int'($urandom_range(0, 18));
      end else m_axis_tready <= 1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [22:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      REG_CPT:  g_cpt = val[19:0];
      REG_EMF:  g_emf = val[21:0];
      REG_RES:  g_res = val[21:0];
      REG_IMAX: g_imax = val[21:0];
      REG_TMAX: g_tmax = val[22:0];
      REG_LO:   g_lo = val[18:0];
      REG_HI:   g_hi = val[18:0];
      REG_POL:  g_pol = val[1:0];
      default:  ;
    endcase
  endtask

  task automatic send_sample(logic [23:0] tq, logic [18:0] ang, logic [24:0] rate,
                             logic [21:0] bus);
    int gap;
    if (!quiet && $urandom_range(0, 15) == 0) begin
      gap = int'($urandom_range(1, 19));
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'd0, bus, rate, ang, tq};
    cmd_q.push_back(drive_cmd(tq, ang, rate, bus));
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [23:0] tq[6] = '{24'h7FFFFF, 24'h800000, 24'd0, 24'd65536, -24'sd65536, 24'd1};
    send_sample(24'd65536, 19'd0, 25'd0, 22'd65536);  // polarity unset: invalid
    drain();
    write_reg(REG_POL, 23'(PolPos));
    foreach (tq[i]) send_sample(tq[i], 19'd0, 25'd0, 22'd65536);
    send_sample(24'd65536, 19'd65536, 25'd0, 22'd65536);       // brake at upper stop
    send_sample(-24'sd65536, -19'sd65536, 25'd0, 22'd65536);   // brake at lower stop
    send_sample(-24'sd65536, 19'h3FFFF, 25'd0, 22'd65536);     // away from upper stop
    send_sample(24'd0, -19'sd65536, 25'd0, 22'd65536);         // zero torque at lower
    send_sample(24'd1000, 19'd0, 25'h0FFFFFF, 22'h3FFFFF);     // voltage above bus: duty full
    send_sample(24'd1000, 19'd0, 25'h1000000, 22'h3FFFFF);     // negative voltage above bus: duty full
    send_sample(24'd1000, 19'd0, 25'd0, 22'd0);                // zero bus
    send_sample(24'd30000, 19'd0, -25'sd100, 22'd1);           // duty full
    drain();
  endtask

  task automatic test_invalid_cfg();
    write_reg(REG_LO, 23'd65536);  // lower == upper
    send_sample(24'd100, 19'd0, 25'd5, 22'd9999);
    drain();
    write_reg(REG_LO, 23'(-19'sd65536));
    write_reg(REG_POL, 23'd3);
    send_sample(24'd100, 19'd0, 25'd5, 22'd9999);
    drain();
    write_reg(REG_CPT, 23'd0);
    write_reg(REG_POL, 23'(PolNeg));
    send_sample(24'd100, 19'd0, 25'd5, 22'd9999);
    drain();
  endtask

  task automatic test_random(int n, bit extreme);
    write_reg(REG_CPT, extreme ? 23'hFFFFF : 23'($urandom_range(1, 200000)));
    write_reg(REG_EMF, extreme ? 23'h3FFFFF : 23'($urandom_range(1, 100000)));
    write_reg(REG_RES, extreme ? 23'd1 : 23'($urandom_range(1, 300000)));
    write_reg(REG_IMAX, extreme ? 23'h3FFFFF : 23'($urandom_range(1, 2000000)));
    write_reg(REG_TMAX, extreme ? 23'h7FFFFF : 23'($urandom_range(1, 2000000)));
    write_reg(REG_LO, extreme ? 23'(-19'sd262144) : 23'(-int'($urandom_range(1, 200000))));
    write_reg(REG_HI, extreme ? 23'(19'sd262143) : 23'($urandom_range(0, 200000)));
    write_reg(REG_POL, 23'($urandom_range(1, 2)));
    repeat (n) begin
      int k;
      logic [21:0] bus;
      k = int'($urandom_range(0, 3));
      bus = (k == 0) ? 22'($urandom) : 22'($urandom_range(1, 3000000));
      if ($urandom_range(0, 40) == 0) bus = '0;
      send_sample(24'((k == 1) ? int'($urandom) : int'($urandom_range(0, 400000)) - 200000),
                  19'((k == 2) ? int'($urandom) : int'($urandom_range(0, 140000)) - 70000),
                  25'((k == 3) ? int'($urandom) : int'($urandom_range(0, 200000)) - 100000),
                  bus);
    end
    drain();
  endtask

  initial begin
    g_cpt = 65536; g_emf = 65536; g_res = 65536; g_imax = 65536;
    g_tmax = 65536; g_lo = -65536; g_hi = 65536; g_pol = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_invalid_cfg();
    test_random(400, 0);
    test_random(300, 1);
    test_random(400, 0);
    quiet = 1;
    test_random(400, 0);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ttmdc_pkg.sv
hw/rtl/ttmdc_front.sv
hw/rtl/ttmdc_queue.sv
hw/rtl/ttmdc_back.sv
hw/rtl/torque_to_motor_drive_command.sv
sim/torque_to_motor_drive_command_tb.sv
